// ===== src/shifting_array_list_defines.svh =====
// assertion macros for the shifting array list
// sampled on clk, disabled while rst_n is low; used by the top level
`ifndef SHIFTING_ARRAY_LIST_DEFINES_SVH
`define SHIFTING_ARRAY_LIST_DEFINES_SVH

// condition implies check in the same cycle
`define SAL_ASSERT_NOW(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
    else $error(msg);

// condition implies check in the next cycle
`define SAL_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
    else $error(msg);

`endif

// ===== src/sal_pkg.sv =====
// shared types and constants for the shifting array list
// no dependencies; imported by every module of the block
package sal_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ST_W   = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // list commands
  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_GET      = 3'd2,
    CMD_INDEX_OF = 3'd3,
    CMD_REMOVE   = 3'd4,
    CMD_SWAP     = 3'd5,
    CMD_CLEAR    = 3'd6
  } cmd_t;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

  // per-cell action
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_UP   = 2'd2,
    CELL_DOWN = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    word_t    ld;
  } cell_ctl_t;

  // command result apart from the count fields
  typedef struct packed {
    logic [ST_W-1:0] status;
    word_t           word_out;
    idx_t            found_at;
    logic            found;
  } result_t;

endpackage

// ===== src/sal_cell.sv =====
// one storage cell of the list: holds a word, shifts from a neighbor or loads
// depends on sal_pkg
module sal_cell
  import sal_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  word_t     left_word,
  input  word_t     right_word,
  input  word_t     key,
  output word_t     word_q,
  output logic      hit
);

  word_t word_r;
  word_t word_nxt;

  // next content from own value, neighbor or load data
  always_comb begin
    unique case (ctl.op)
      CELL_LOAD: word_nxt = ctl.ld;
      CELL_UP:   word_nxt = left_word;
      CELL_DOWN: word_nxt = right_word;
      default:   word_nxt = word_r;
    endcase
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // local compare for index_of
  assign hit    = (word_r == key);
  assign word_q = word_r;

endmodule

// ===== src/sal_ctrl.sv =====
// command decode: per-cell actions, next count and result fields
// depends on sal_pkg; driven by the top level with the cell contents
module sal_ctrl
  import sal_pkg::*;
(
  input  logic      go,
  input  cmd_t      cmd,
  input  idx_t      pos,
  input  idx_t      pos2,
  input  word_t     word_in,
  input  cnt_t      count,
  input  word_t     cell_words [DEPTH],
  input  logic      hits [DEPTH],
  output cell_ctl_t ctls [DEPTH],
  output cnt_t      count_nxt,
  output result_t   res
);

  cnt_t  pos_c;
  cnt_t  pos2_c;
  logic  full;
  logic  pos_ok;
  logic  pos2_ok;
  word_t rd_a;
  word_t rd_b;
  logic  any_hit;
  idx_t  hit_at;

  assign pos_c   = {{(CNT_W-IDX_W){1'b0}}, pos};
  assign pos2_c  = {{(CNT_W-IDX_W){1'b0}}, pos2};
  assign full    = (count == CNT_W'(DEPTH));
  assign pos_ok  = (pos_c < count);
  assign pos2_ok = (pos2_c < count);
  assign rd_a    = cell_words[pos];
  assign rd_b    = cell_words[pos2];

  // first live match, lowest index wins
  always_comb begin
    any_hit = 1'b0;
    hit_at  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hits[i] && (CNT_W'(i) < count)) begin
        any_hit = 1'b1;
        hit_at  = IDX_W'(i);
      end
    end
  end

  // per-cell actions
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctls[i].op = CELL_HOLD;
      ctls[i].ld = word_in;
      if (go) begin
        case (cmd)
          CMD_APPEND: begin
            if (!full && (CNT_W'(i) == count)) ctls[i].op = CELL_LOAD;
          end
          CMD_INSERT: begin
            if (pos_ok && !full) begin
              if (IDX_W'(i) == pos) begin
                ctls[i].op = CELL_LOAD;
              end else if ((CNT_W'(i) > pos_c) && (CNT_W'(i) <= count)) begin
                ctls[i].op = CELL_UP;
              end
            end
          end
          CMD_REMOVE: begin
            if (pos_ok && (CNT_W'(i) >= pos_c) && (CNT_W'(i + 1) < count)) begin
              ctls[i].op = CELL_DOWN;
            end
          end
          CMD_SWAP: begin
            if (pos_ok && pos2_ok) begin
              if (IDX_W'(i) == pos2) begin
                ctls[i].op = CELL_LOAD;
                ctls[i].ld = rd_a;
              end
              if (IDX_W'(i) == pos) begin
                ctls[i].op = CELL_LOAD;
                ctls[i].ld = rd_b;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // next count and result fields
  always_comb begin
    count_nxt    = count;
    res.status   = ST_OK;
    res.word_out = '0;
    res.found_at = '0;
    res.found    = 1'b0;
    case (cmd)
      CMD_APPEND: begin
        if (full) res.status = ST_FULL;
        else      count_nxt = count + 1'b1;
      end
      CMD_INSERT: begin
        if (!pos_ok)   res.status = ST_BAD;
        else if (full) res.status = ST_FULL;
        else           count_nxt = count + 1'b1;
      end
      CMD_GET: begin
        if (!pos_ok) res.status = ST_BAD;
        else         res.word_out = rd_a;
      end
      CMD_INDEX_OF: begin
        if (any_hit) begin
          res.found_at = hit_at;
          res.found    = 1'b1;
        end else begin
          res.status = ST_BAD;
        end
      end
      CMD_REMOVE: begin
        if (!pos_ok) res.status = ST_BAD;
        else         count_nxt = count - 1'b1;
      end
      CMD_SWAP: begin
        if (!(pos_ok && pos2_ok)) res.status = ST_BAD;
      end
      CMD_CLEAR: count_nxt = '0;
      default: ;
    endcase
  end

endmodule

// ===== src/shifting_array_list.sv =====
// shifting array list: the result word is registered at acceptance
// throughput one command per cycle while in_tready is high; every cell shifts, compares or loads in the accepting cycle
// the output register is refilled in the cycle it is drained, so no bubble under backpressure
// reset clears the word count and the output valid; cell contents stay undefined until written
// depends on sal_pkg, sal_cell, sal_ctrl and shifting_array_list_defines.svh
`include "shifting_array_list_defines.svh"

module shifting_array_list
  import sal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[2:0], position[6:3], other_position[10:7], word_in[42:11], zero fill
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], word_out[33:2], found_at[37:34], found[38], fill_count[43:39],
  // empty_res[44], zero fill
  output logic [47:0] out_tdata
);

  logic        in_acc;
  cmd_t        cmd;
  idx_t        pos;
  idx_t        pos2;
  word_t       word_in;
  cnt_t        count_r;
  cnt_t        count_nxt;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  result_t     res;
  word_t       cell_words [DEPTH];
  logic        hits [DEPTH];
  cell_ctl_t   ctls [DEPTH];

  // input word unpack
  assign cmd     = cmd_t'(in_tdata[2:0]);
  assign pos     = in_tdata[6:3];
  assign pos2    = in_tdata[10:7];
  assign word_in = in_tdata[42:11];

  // accept whenever the output register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // row of cells, each fed by its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_words[g];
    end else begin : g_mid_l
      assign left_w = cell_words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_words[g];
    end else begin : g_mid_r
      assign right_w = cell_words[g+1];
    end
    sal_cell u_cell (
      .clk        (clk),
      .ctl        (ctls[g]),
      .left_word  (left_w),
      .right_word (right_w),
      .key        (word_in),
      .word_q     (cell_words[g]),
      .hit        (hits[g])
    );
  end

  // command decode
  sal_ctrl u_ctrl (
    .go         (in_acc),
    .cmd        (cmd),
    .pos        (pos),
    .pos2       (pos2),
    .word_in    (word_in),
    .count      (count_r),
    .cell_words (cell_words),
    .hits       (hits),
    .ctls       (ctls),
    .count_nxt  (count_nxt),
    .res        (res)
  );

  // count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      count_r     <= count_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {3'b000, (count_nxt == '0), count_nxt, res.found, res.found_at,
                     res.word_out, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `SAL_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `SAL_ASSERT_NEXT(a_clear_empties, in_acc && (cmd == CMD_CLEAR), count_r == '0,
                   "clear left words in the list")
  `SAL_ASSERT_NOW(a_full_status, out_valid_r && (out_data_r[1:0] == ST_FULL),
                  out_data_r[43:39] == CNT_W'(DEPTH), "full status with room left")
  `SAL_ASSERT_NOW(a_empty_flag, out_valid_r,
                  out_data_r[44] == (out_data_r[43:39] == '0), "empty flag disagrees with count")

endmodule
